FILE: rtl/dual_incremental_pi_speed_top_assert.svh
// assertion macros for the speed loop
`ifndef DUAL_INCREMENTAL_PI_SPEED_TOP_ASSERT_SVH
`define DUAL_INCREMENTAL_PI_SPEED_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DIPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DIPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dipi_pkg.sv
package dipi_pkg;

    // field widths
    localparam int ERR_W     = 16;
    localparam int GAIN_W    = 12;
    localparam int LIMIT_W   = 15;
    localparam int FRAC_BITS = 8;

    // datapath widths
    localparam int DIFF_W    = ERR_W + 1;
    localparam int KI_PROD_W = ERR_W + GAIN_W + 1;
    localparam int KP_PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SCALED_W  = KP_PROD_W + 1;
    localparam int DELTA_W   = SCALED_W - FRAC_BITS;
    localparam int SUM_W     = DELTA_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIMIT_W;

    // register reset values
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(640);
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = GAIN_W'(256);
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = LIMIT_W'(1200);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_INTEG_GAIN  = 2'd1,
        REG_DRIVE_LIMIT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [LIMIT_W-1:0] drive_limit;
    } dipi_cfg_t;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s2_clear;
    } dipi_ctl_t;

endpackage

FILE: rtl/dipi_cfg.sv
module dipi_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dipi_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [dipi_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output dipi_pkg::dipi_cfg_t                 cfg
);

    dipi_pkg::dipi_cfg_t cfg_reg;
    dipi_pkg::dipi_cfg_t cfg_next;

    // register decode, unknown index leaves everything as is
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (dipi_pkg::reg_idx_t'(cfg_wr_index))
                dipi_pkg::REG_PROP_GAIN: begin
                    cfg_next.prop_gain = cfg_wr_data[dipi_pkg::GAIN_W-1:0];
                end
                dipi_pkg::REG_INTEG_GAIN: begin
                    cfg_next.integ_gain = cfg_wr_data[dipi_pkg::GAIN_W-1:0];
                end
                dipi_pkg::REG_DRIVE_LIMIT: begin
                    cfg_next.drive_limit = cfg_wr_data[dipi_pkg::LIMIT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain   <= dipi_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain  <= dipi_pkg::INTEG_GAIN_RST;
            cfg_reg.drive_limit <= dipi_pkg::DRIVE_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dipi_wheel.sv
module dipi_wheel (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dipi_pkg::dipi_ctl_t                   ctl,
    input  dipi_pkg::dipi_cfg_t                   cfg,
    input  logic signed [dipi_pkg::ERR_W-1:0]     target,
    input  logic signed [dipi_pkg::ERR_W-1:0]     measured,
    output logic signed [dipi_pkg::ERR_W-1:0]     drive
);

    // stage 1: error and integral product
    logic signed [dipi_pkg::ERR_W-1:0]     err_next;
    logic signed [dipi_pkg::GAIN_W:0]      ki_s;
    logic signed [dipi_pkg::KI_PROD_W-1:0] ki_err_next;
    logic signed [dipi_pkg::ERR_W-1:0]     err_reg;
    logic signed [dipi_pkg::KI_PROD_W-1:0] ki_err_reg;

    // stage 2: proportional term, accumulate and clamp
    logic signed [dipi_pkg::GAIN_W:0]      kp_s;
    logic signed [dipi_pkg::DIFF_W-1:0]    diff;
    logic signed [dipi_pkg::KP_PROD_W-1:0] kp_diff;
    logic signed [dipi_pkg::SCALED_W-1:0]  scaled;
    logic signed [dipi_pkg::DELTA_W-1:0]   delta_floor;
    logic                                  round_up;
    logic signed [dipi_pkg::DELTA_W-1:0]   delta;
    logic signed [dipi_pkg::SUM_W-1:0]     sum;
    logic signed [dipi_pkg::SUM_W-1:0]     lim_pos;
    logic signed [dipi_pkg::SUM_W-1:0]     lim_neg;
    logic signed [dipi_pkg::SUM_W-1:0]     clamped;

    logic signed [dipi_pkg::ERR_W-1:0]     prev_err_reg;
    logic signed [dipi_pkg::ERR_W-1:0]     prev_err_next;
    logic signed [dipi_pkg::ERR_W-1:0]     accum_reg;
    logic signed [dipi_pkg::ERR_W-1:0]     accum_next;

    // error wraps to 16 bits
    assign err_next    = target - measured;
    assign ki_s        = $signed({1'b0, cfg.integ_gain});
    assign ki_err_next = dipi_pkg::KI_PROD_W'(err_next) * dipi_pkg::KI_PROD_W'(ki_s);

    always_ff @(posedge aclk) begin
        if (ctl.s1_load) begin
            err_reg    <= err_next;
            ki_err_reg <= ki_err_next;
        end
    end

    // kp*(err - prev_err) + ki*err in units of 1/256
    assign kp_s    = $signed({1'b0, cfg.prop_gain});
    assign diff    = dipi_pkg::DIFF_W'(err_reg) - dipi_pkg::DIFF_W'(prev_err_reg);
    assign kp_diff = dipi_pkg::KP_PROD_W'(diff) * dipi_pkg::KP_PROD_W'(kp_s);
    assign scaled  = dipi_pkg::SCALED_W'(kp_diff) + dipi_pkg::SCALED_W'(ki_err_reg);

    // drop fraction toward zero: floor, then bump negatives with a remainder
    assign delta_floor = dipi_pkg::DELTA_W'(scaled >>> dipi_pkg::FRAC_BITS);
    assign round_up    = scaled[dipi_pkg::SCALED_W-1]
                         && (scaled[dipi_pkg::FRAC_BITS-1:0] != '0);
    assign delta       = delta_floor
                         + $signed({{(dipi_pkg::DELTA_W-1){1'b0}}, round_up});

    // wide sum saturates at the symmetric limit
    assign sum     = dipi_pkg::SUM_W'(accum_reg) + dipi_pkg::SUM_W'(delta);
    assign lim_pos = $signed({{(dipi_pkg::SUM_W-dipi_pkg::LIMIT_W){1'b0}}, cfg.drive_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (sum > lim_pos) begin
            clamped = lim_pos;
        end else if (sum < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = sum;
        end
    end

    // state update, clear zeroes the loop
    always_comb begin
        prev_err_next = prev_err_reg;
        accum_next    = accum_reg;
        if (ctl.s2_load) begin
            if (ctl.s2_clear) begin
                prev_err_next = '0;
                accum_next    = '0;
            end else begin
                prev_err_next = err_reg;
                accum_next    = clamped[dipi_pkg::ERR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            accum_reg    <= '0;
        end else begin
            prev_err_reg <= prev_err_next;
            accum_reg    <= accum_next;
        end
    end

    // accumulator doubles as the result register
    assign drive = accum_reg;

endmodule

FILE: rtl/dual_incremental_pi_speed_top.sv
// pipeline: input register then result register; an accepted item waits in the input
//   register until the result register is free, then moves into it
// throughput: one item per cycle unless a stalled result holds stage 1; the accumulator
//   update (multiply, add, clamp) closes its feedback loop through each wheel's register
// reset: aresetn synchronous, active low; clears both loop states and the
//   pipeline valids and loads gains 2.5 / 1.0 and drive limit 1200
module dual_incremental_pi_speed_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [dipi_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [dipi_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // input item stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_left, measured_left, target_right, measured_right
    input  logic [63:0]                         s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,
    // result item stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // drive_left_out, drive_right_out
    output logic [31:0]                         m_axis_tdata
);

    `include "dual_incremental_pi_speed_top_assert.svh"

    dipi_pkg::dipi_cfg_t cfg;
    dipi_pkg::dipi_ctl_t ctl;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_cmd_reg;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;
    logic s_fire;
    logic s2_fire;

    logic signed [dipi_pkg::ERR_W-1:0] drive_left;
    logic signed [dipi_pkg::ERR_W-1:0] drive_right;

    dipi_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // handshake: stage 1 holds an item, result register waits for the sink
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s2_fire       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || s2_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s2_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s2_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_cmd_reg <= s_axis_tuser;
        end
    end

    assign ctl.s1_load  = s_fire;
    assign ctl.s2_load  = s2_fire;
    assign ctl.s2_clear = s1_cmd_reg;

    // one datapath per wheel
    dipi_wheel u_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .cfg      (cfg),
        .target   ($signed(s_axis_tdata[15:0])),
        .measured ($signed(s_axis_tdata[31:16])),
        .drive    (drive_left)
    );

    dipi_wheel u_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .cfg      (cfg),
        .target   ($signed(s_axis_tdata[47:32])),
        .measured ($signed(s_axis_tdata[63:48])),
        .drive    (drive_right)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {drive_right, drive_left};

    // range check helpers
    logic signed [dipi_pkg::LIMIT_W+1:0] lim_chk;
    logic                                left_ok;
    logic                                right_ok;
    logic                                drive_ok;
    logic                                clear_fire;
    logic                                s1_stall;

    assign lim_chk  = $signed({2'b00, cfg.drive_limit});
    assign left_ok  = ((dipi_pkg::LIMIT_W+2)'(drive_left) <= lim_chk)
                      && ((dipi_pkg::LIMIT_W+2)'(drive_left) >= -lim_chk);
    assign right_ok = ((dipi_pkg::LIMIT_W+2)'(drive_right) <= lim_chk)
                      && ((dipi_pkg::LIMIT_W+2)'(drive_right) >= -lim_chk);
    assign drive_ok   = left_ok && right_ok;
    assign clear_fire = s2_fire && s1_cmd_reg;
    assign s1_stall   = s1_valid_reg && !out_free;

    // a clear item yields an all-zero result
    `DIPI_ASSERT_NEXT(a_clear_zero, aclk, aresetn, clear_fire, m_axis_tdata == '0, "bad clear")

    // every update produces a result on the next cycle
    `DIPI_ASSERT_NEXT(a_result_follows, aclk, aresetn, s2_fire, m_axis_tvalid, "no result")

    // stage 1 never takes a new item while its item is stuck
    `DIPI_ASSERT_NOW(a_no_overrun, aclk, aresetn, s1_stall, !s_axis_tready, "overrun")

    // an update only ever leaves the drive inside the clamp
    `DIPI_ASSERT_NEXT(a_drive_range, aclk, aresetn, s2_fire, drive_ok, "drive outside limit")

endmodule

FILE: tb/tb_dual_incremental_pi_speed_top.sv
`timescale 1ns / 100ps

module tb_dual_incremental_pi_speed_top;

    // index with no register behind it, writes must be dropped
    localparam logic [dipi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    typedef struct packed {
        logic signed [15:0] drive_right;
        logic signed [15:0] drive_left;
    } drive_pair_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [dipi_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [dipi_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [63:0]                     s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [31:0]                     m_axis_tdata;

    // predicted loop state and register copy
    logic [dipi_pkg::GAIN_W-1:0]  kp_q48 = dipi_pkg::PROP_GAIN_RST;
    logic [dipi_pkg::GAIN_W-1:0]  ki_q48 = dipi_pkg::INTEG_GAIN_RST;
    logic [dipi_pkg::LIMIT_W-1:0] drive_lim = dipi_pkg::DRIVE_LIMIT_RST;
    logic signed [15:0] err_hist [2] = '{16'sd0, 16'sd0};
    logic signed [15:0] drive_acc [2] = '{16'sd0, 16'sd0};

    drive_pair_t drive_expect_q [$];
    drive_pair_t drive_want;
    drive_pair_t drive_got;
    int          mismatch_count = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;

    dual_incremental_pi_speed_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one wheel: wrapped error, Q4.8 PI increment truncated toward zero, clamp
    function automatic logic signed [15:0] wheel_drive_step(input int w,
            input logic signed [15:0] target, input logic signed [15:0] measured);
        logic signed [15:0] err;
        longint change;
        longint scaled;
        longint total;
        longint lim;
        err = target - measured;
        change = longint'(err) - longint'(err_hist[w]);
        scaled = longint'(kp_q48) * change + longint'(ki_q48) * longint'(err);
        total = longint'(drive_acc[w]) + scaled / 256;
        lim = longint'(drive_lim);
        if (total > lim)
            total = lim;
        else if (total < -lim)
            total = -lim;
        err_hist[w] = err;
        drive_acc[w] = 16'(total);
        return 16'(total);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // sender: random gap, hold item until accepted, then predict its result
    task automatic send_item(input logic clr, input logic signed [15:0] tl,
            input logic signed [15:0] ml, input logic signed [15:0] tr,
            input logic signed [15:0] mr);
        drive_pair_t res;
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mr, tr, ml, tl};
        s_axis_tuser  <= clr;
        do @(posedge aclk); while (!s_axis_tready);
        if (clr) begin
            err_hist  = '{16'sd0, 16'sd0};
            drive_acc = '{16'sd0, 16'sd0};
            res = '0;
        end else begin
            res.drive_left  = wheel_drive_step(LEFT, tl, ml);
            res.drive_right = wheel_drive_step(RIGHT, tr, mr);
        end
        drive_expect_q.push_back(res);
    endtask

    // stop sending and let every expected result come out
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (drive_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [dipi_pkg::CFG_IDX_W-1:0] idx,
            input logic [dipi_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        case (idx)
            dipi_pkg::REG_PROP_GAIN:   kp_q48 = value[dipi_pkg::GAIN_W-1:0];
            dipi_pkg::REG_INTEG_GAIN:  ki_q48 = value[dipi_pkg::GAIN_W-1:0];
            dipi_pkg::REG_DRIVE_LIMIT: drive_lim = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(posedge aclk)
        m_axis_tready <= (sink_idle_pct == 0) || ($urandom_range(0, 99) >= sink_idle_pct);

    // result check against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            drive_got = m_axis_tdata;
            if (drive_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                drive_want = drive_expect_q.pop_front();
                if (drive_got.drive_left !== drive_want.drive_left)
                    report_mismatch($sformatf("drive_left_out expected %0d got %0d",
                        drive_want.drive_left, drive_got.drive_left));
                if (drive_got.drive_right !== drive_want.drive_right)
                    report_mismatch($sformatf("drive_right_out expected %0d got %0d",
                        drive_want.drive_right, drive_got.drive_right));
            end
        end
    end

    // reset gains and limit, small steps around zero
    task automatic test_default_gains();
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_item(1'b0, 16'sd100, 16'sd0, -16'sd100, 16'sd0);
        send_item(1'b0, 16'sd100, 16'sd0, -16'sd100, 16'sd0);
        send_item(1'b0, 16'sd0, 16'sd100, 16'sd0, -16'sd100);
        send_item(1'b0, 16'sd50, 16'sd60, -16'sd50, -16'sd60);
    endtask

    // target minus measured wraps in 16 bits
    task automatic test_error_wrap();
        send_item(1'b0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_item(1'b0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_item(1'b0, 16'sd0, 16'sh8000, -16'sd1, 16'sh7fff);
    endtask

    // clear zeroes loop state and ignores the speed fields
    task automatic test_clear_cmd();
        send_item(1'b1, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_item(1'b0, 16'sd10, 16'sd0, -16'sd10, 16'sd0);
        send_item(1'b1, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
        send_item(1'b0, -16'sd7, 16'sd3, 16'sd7, -16'sd3);
    endtask

    // masking of wide writes, unused index, limit and gain extremes
    task automatic test_register_writes();
        drain_pipeline();
        cfg_write(dipi_pkg::REG_PROP_GAIN, 15'h7fff);
        cfg_write(dipi_pkg::REG_INTEG_GAIN, 15'h7fff);
        cfg_write(dipi_pkg::REG_DRIVE_LIMIT, 15'h7fff);
        cfg_write(REG_UNUSED, 15'h0000);
        send_item(1'b0, 16'sh7fff, 16'sd0, 16'sh8000, 16'sd0);
        send_item(1'b0, 16'sh8000, 16'sd0, 16'sh7fff, 16'sd0);
        send_item(1'b0, 16'sh7fff, 16'sh8001, 16'sh8000, 16'sh7fff);
        drain_pipeline();
        cfg_write(dipi_pkg::REG_DRIVE_LIMIT, 15'd0);
        send_item(1'b0, 16'sd5000, 16'sd0, -16'sd5000, 16'sd0);
        send_item(1'b0, -16'sd5000, 16'sd0, 16'sd5000, 16'sd0);
        drain_pipeline();
        cfg_write(dipi_pkg::REG_PROP_GAIN, 15'd0);
        cfg_write(dipi_pkg::REG_INTEG_GAIN, 15'd0);
        cfg_write(dipi_pkg::REG_DRIVE_LIMIT, 15'(dipi_pkg::DRIVE_LIMIT_RST));
        send_item(1'b0, 16'sd300, 16'sd0, -16'sd300, 16'sd0);
        send_item(1'b0, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd0);
        drain_pipeline();
        cfg_write(dipi_pkg::REG_PROP_GAIN, 15'(dipi_pkg::PROP_GAIN_RST));
        cfg_write(dipi_pkg::REG_INTEG_GAIN, 15'(dipi_pkg::INTEG_GAIN_RST));
    endtask

    // mostly tracking traffic, some wide swings, full-range noise and clears
    task automatic test_random_traffic(input int n_items);
        logic signed [15:0] tl, ml, tr, mr;
        int kind;
        for (int i = 0; i < n_items; i++) begin
            kind = $urandom_range(0, 99);
            tl = 16'($urandom);
            ml = 16'($urandom);
            tr = 16'($urandom);
            mr = 16'($urandom);
            if (kind < 55) begin
                ml = tl + 16'($urandom_range(0, 600)) - 16'd300;
                mr = tr + 16'($urandom_range(0, 600)) - 16'd300;
            end else if (kind < 78) begin
                tl = 16'($urandom_range(0, 6000)) - 16'd3000;
                ml = 16'($urandom_range(0, 6000)) - 16'd3000;
                tr = 16'($urandom_range(0, 6000)) - 16'd3000;
                mr = 16'($urandom_range(0, 6000)) - 16'd3000;
            end
            send_item(kind >= 97, tl, ml, tr, mr);
        end
    endtask

    initial begin
        src_idle_pct  = 34;
        sink_idle_pct = 52;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_gains();
        test_error_wrap();
        test_clear_cmd();
        test_register_writes();
        test_random_traffic(630);

        drain_pipeline();
        src_idle_pct  = 52;
        sink_idle_pct = 34;
        cfg_write(dipi_pkg::REG_PROP_GAIN, 15'($urandom_range(0, 1023)));
        cfg_write(dipi_pkg::REG_INTEG_GAIN, 15'($urandom_range(0, 1023)));
        cfg_write(dipi_pkg::REG_DRIVE_LIMIT, 15'($urandom_range(500, 20000)));
        test_random_traffic(630);

        drain_pipeline();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        cfg_write(dipi_pkg::REG_PROP_GAIN, 15'd4095);
        cfg_write(dipi_pkg::REG_INTEG_GAIN, 15'($urandom_range(0, 4095)));
        cfg_write(dipi_pkg::REG_DRIVE_LIMIT, 15'd32767);
        test_random_traffic(640);

        drain_pipeline();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: dual_incremental_pi_speed_top.f
+incdir+rtl
rtl/dipi_pkg.sv
rtl/dipi_cfg.sv
rtl/dipi_wheel.sv
rtl/dual_incremental_pi_speed_top.sv
tb/tb_dual_incremental_pi_speed_top.sv
